### hw/rtl/tt_beat_pkg.sv
// Package: shared constants, types and helpers of the tap tempo beat generator.
package tt_beat_pkg;

    localparam int TT_TIME_W      = 24;
    localparam int TT_LOW_W       = 16;
    localparam int TT_HIGH_W      = TT_TIME_W - TT_LOW_W;
    localparam int TT_INTERVAL_W  = 16;
    localparam int TT_COUNT_W     = 8;
    localparam int TT_LIMIT_W     = 4;
    localparam int TT_DIVIDEND_W  = TT_TIME_W + 1;
    localparam int TT_LED_W       = 4;
    localparam int TT_PHASE_OUT_W = 4;
    localparam int TT_PHASE_BITS  = 4;

    localparam int TT_CFG_ADDR_W  = 2;
    localparam int TT_CFG_DATA_W  = 16;
    localparam int TT_S_DATA_W    = 8;
    localparam int TT_M_DATA_W    = 16;

    localparam logic [TT_CFG_ADDR_W-1:0] CFG_MIN_INTERVAL   = 2'd0;
    localparam logic [TT_CFG_ADDR_W-1:0] CFG_TAP_GAP_LIMIT  = 2'd1;
    localparam logic [TT_CFG_ADDR_W-1:0] CFG_IDLE_GAP_LIMIT = 2'd2;

    localparam logic [TT_INTERVAL_W-1:0] MIN_INTERVAL_RST   = 16'd1024;
    localparam logic [TT_LIMIT_W-1:0]    TAP_GAP_LIMIT_RST  = 4'd2;
    localparam logic [TT_LIMIT_W-1:0]    IDLE_GAP_LIMIT_RST = 4'd7;

    localparam logic [TT_COUNT_W-1:0]    TAP_COUNT_MAX = '1;
    localparam logic [TT_LED_W-1:0]      LED_ALL       = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CTRL,
        ST_DIVIDE,
        ST_ALIGN,
        ST_MATCH,
        ST_EMIT
    } tt_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tt_div_status_t;

    // Sixteenth of the interval, rounded.
    function automatic logic [TT_INTERVAL_W-1:0] compare_step(
        input logic [TT_INTERVAL_W-1:0] interval
    );
        logic [TT_INTERVAL_W:0] sum;
        sum = {1'b0, interval} + (TT_INTERVAL_W+1)'(8);
        return TT_INTERVAL_W'(sum >> 4);
    endfunction

endpackage

### hw/rtl/tap_tempo_beat_generator_core.sv
// Top level: tap tempo beat generator with sequencer and shared divider.
//
//  Channel   Direction  Handshake                     Content
//  s_axis    in         s_axis_tvalid/s_axis_tready   tick, strobe, start, tap
//  m_axis    out        m_axis_tvalid/m_axis_tready   phase, LEDs, tapping flag
//  cfg       in         cfg_valid/cfg_ready           register index and data
//
// An item without an accepted tap goes from the idle state through control, match
// and emit to the result register; an accepted tap adds the divide state, which
// waits for the divider (one iteration per dividend bit), and the align state. Input
// ready is high only in the idle state; a result waiting in the output register
// holds the sequencer in its emit state until taken. Synchronous reset (aresetn low)
// loads register defaults and clears all state but output data and divider datapath.
module tap_tempo_beat_generator_core #(
    parameter int PHASE_BITS = tt_beat_pkg::TT_PHASE_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [0] timer_tick, [1] frame_strobe, [2] start_button, [3] tap_button
    input  logic [tt_beat_pkg::TT_S_DATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [3:0] phase_out, [7:4] led_out, [8] tapping_flag
    output logic [tt_beat_pkg::TT_M_DATA_W-1:0]    m_axis_tdata,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tt_beat_pkg::TT_CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [tt_beat_pkg::TT_CFG_DATA_W-1:0]  cfg_wdata
);
    import tt_beat_pkg::*;

    localparam int PHASE_EXT_W = (PHASE_BITS > TT_PHASE_OUT_W) ? PHASE_BITS : TT_PHASE_OUT_W;
    localparam int STOP_W      = TT_INTERVAL_W + TT_LIMIT_W;

    tt_state_t state_reg, state_next;

    logic [TT_INTERVAL_W-1:0] min_interval_reg;
    logic [TT_LIMIT_W-1:0]    tap_gap_limit_reg, idle_gap_limit_reg;

    logic [TT_LOW_W-1:0]      time_low_reg, time_low_next;
    logic [TT_HIGH_W-1:0]     time_high_reg, time_high_next;
    logic [TT_INTERVAL_W-1:0] compare_value_reg, compare_value_next;
    logic                     compare_hit_reg, compare_hit_next;
    logic [TT_INTERVAL_W-1:0] beat_interval_reg, beat_interval_next;
    logic [TT_TIME_W-1:0]     last_tap_time_reg, last_tap_time_next;
    logic [TT_COUNT_W-1:0]    tap_count_reg, tap_count_next;
    logic                     tapping_on_reg, tapping_on_next;
    logic [PHASE_BITS-1:0]    beat_phase_reg, beat_phase_next;
    logic [TT_LED_W-1:0]      led_pending_reg, led_pending_next;
    logic [TT_LED_W-1:0]      led_shown_reg, led_shown_next;
    logic [TT_PHASE_OUT_W-1:0] phase_shown_reg, phase_shown_next;
    logic [1:0]               prev_buttons_reg, prev_buttons_next;
    logic [1:0]               presses_reg, presses_next;

    logic                     m_valid_reg, m_valid_next;
    logic [TT_M_DATA_W-1:0]   m_data_reg, m_data_next;

    logic                     s_accept;
    logic                     out_free;
    logic                     in_tick, in_strobe;
    logic [1:0]               in_buttons;
    logic [TT_LOW_W-1:0]      time_low_inc;
    logic [TT_TIME_W-1:0]     now;
    logic [TT_COUNT_W-1:0]    count_inc;
    logic                     tap_ok;

    logic                     div_start;
    logic [TT_DIVIDEND_W-1:0] div_dividend;
    logic [TT_DIVIDEND_W-1:0] div_quotient;
    tt_div_status_t           div_status;
    logic [TT_INTERVAL_W-1:0] mean_sat;

    logic [PHASE_BITS-1:0]    phase_inc;
    logic [PHASE_EXT_W-1:0]   phase_ext;
    logic [PHASE_EXT_W-1:0]   fell_ext;
    logic [TT_TIME_W-1:0]     since;
    logic [STOP_W-1:0]        tap_span, idle_span;
    logic                     stop_check, stop_hit;

    assign in_tick      = s_axis_tdata[0];
    assign in_strobe    = s_axis_tdata[1];
    assign in_buttons   = s_axis_tdata[3:2];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free     = !m_valid_reg || m_axis_tready;
    assign cfg_ready    = 1'b1;

    assign time_low_inc = time_low_reg + TT_LOW_W'(1);
    assign now          = {time_high_reg, time_low_reg};
    assign count_inc    = (tap_count_reg == TAP_COUNT_MAX) ? tap_count_reg
                                                           : tap_count_reg + TT_COUNT_W'(1);
    assign tap_ok       = tapping_on_reg && presses_reg[1]
                          && (now > TT_TIME_W'(min_interval_reg));
    // Dividend adds half the new count for rounding.
    assign div_dividend = TT_DIVIDEND_W'(now) + TT_DIVIDEND_W'(count_inc >> 1);
    assign div_start    = (state_reg == ST_CTRL) && !presses_reg[0] && tap_ok;
    assign mean_sat     = (div_quotient[TT_DIVIDEND_W-1:TT_INTERVAL_W] != '0)
                          ? '1 : div_quotient[TT_INTERVAL_W-1:0];

    assign phase_inc  = beat_phase_reg + PHASE_BITS'(1);
    assign phase_ext  = PHASE_EXT_W'(beat_phase_reg);
    assign fell_ext   = PHASE_EXT_W'(beat_phase_reg & ~phase_inc);
    assign since      = now - last_tap_time_reg;
    assign tap_span   = STOP_W'(tap_gap_limit_reg) * STOP_W'(beat_interval_reg);
    assign idle_span  = STOP_W'(idle_gap_limit_reg) * STOP_W'(beat_interval_reg);
    assign stop_check = tapping_on_reg && (now != '0) && (beat_interval_reg > min_interval_reg);
    assign stop_hit   = ((tap_count_reg != '0) && (since > TT_TIME_W'(tap_span)))
                        || (since > TT_TIME_W'(idle_span));

    tt_beat_divider #(
        .DIVIDEND_W (TT_DIVIDEND_W),
        .DIVISOR_W  (TT_COUNT_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_inc),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next         = state_reg;
        time_low_next      = time_low_reg;
        time_high_next     = time_high_reg;
        compare_value_next = compare_value_reg;
        compare_hit_next   = compare_hit_reg;
        beat_interval_next = beat_interval_reg;
        last_tap_time_next = last_tap_time_reg;
        tap_count_next     = tap_count_reg;
        tapping_on_next    = tapping_on_reg;
        beat_phase_next    = beat_phase_reg;
        led_pending_next   = led_pending_reg;
        led_shown_next     = led_shown_reg;
        phase_shown_next   = phase_shown_reg;
        prev_buttons_next  = prev_buttons_reg;
        presses_next       = presses_reg;
        m_valid_next       = m_valid_reg && !m_axis_tready;
        m_data_next        = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    presses_next = '0;
                    if (in_tick) begin
                        time_low_next = time_low_inc;
                        if (time_low_inc == '0) begin
                            time_high_next = time_high_reg + TT_HIGH_W'(1);
                        end
                        if (time_low_inc == compare_value_reg) begin
                            compare_hit_next = 1'b1;
                        end
                    end
                    if (in_strobe) begin
                        led_shown_next    = led_pending_reg;
                        led_pending_next  = '0;
                        phase_shown_next  = phase_ext[TT_PHASE_OUT_W-1:0];
                        presses_next      = in_buttons & ~prev_buttons_reg;
                        prev_buttons_next = in_buttons;
                    end
                    state_next = ST_CTRL;
                end
            end
            ST_CTRL: begin
                state_next = ST_MATCH;
                if (presses_reg[0]) begin
                    time_low_next      = '0;
                    time_high_next     = '0;
                    compare_value_next = compare_step(beat_interval_reg);
                    compare_hit_next   = 1'b0;
                    tapping_on_next    = 1'b1;
                    led_pending_next   = LED_ALL;
                    beat_phase_next    = '0;
                    last_tap_time_next = '0;
                    tap_count_next     = '0;
                end else if (tap_ok) begin
                    tap_count_next     = count_inc;
                    last_tap_time_next = now;
                    state_next         = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_status.done) begin
                    if (mean_sat > min_interval_reg) begin
                        beat_interval_next = mean_sat;
                    end
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                // Realign on the new interval.
                compare_value_next = last_tap_time_reg[TT_INTERVAL_W-1:0]
                                     + compare_step(beat_interval_reg);
                state_next = ST_MATCH;
            end
            ST_MATCH: begin
                if (compare_hit_reg) begin
                    compare_value_next = compare_value_reg + compare_step(beat_interval_reg);
                    compare_hit_next   = 1'b0;
                    beat_phase_next    = phase_inc;
                    led_pending_next   = fell_ext[TT_LED_W-1:0];
                    if (stop_check && stop_hit) begin
                        tapping_on_next    = 1'b0;
                        tap_count_next     = '0;
                        last_tap_time_next = '0;
                    end
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = TT_M_DATA_W'({tapping_on_reg, led_shown_reg, phase_shown_reg});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            min_interval_reg   <= MIN_INTERVAL_RST;
            tap_gap_limit_reg  <= TAP_GAP_LIMIT_RST;
            idle_gap_limit_reg <= IDLE_GAP_LIMIT_RST;
            time_low_reg       <= '0;
            time_high_reg      <= '0;
            compare_value_reg  <= '0;
            compare_hit_reg    <= 1'b0;
            beat_interval_reg  <= '0;
            last_tap_time_reg  <= '0;
            tap_count_reg      <= '0;
            tapping_on_reg     <= 1'b0;
            beat_phase_reg     <= '0;
            led_pending_reg    <= '0;
            led_shown_reg      <= '0;
            phase_shown_reg    <= '0;
            prev_buttons_reg   <= '0;
            presses_reg        <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    CFG_MIN_INTERVAL:   min_interval_reg   <= cfg_wdata;
                    CFG_TAP_GAP_LIMIT:  tap_gap_limit_reg  <= cfg_wdata[TT_LIMIT_W-1:0];
                    CFG_IDLE_GAP_LIMIT: idle_gap_limit_reg <= cfg_wdata[TT_LIMIT_W-1:0];
                    default: ;
                endcase
            end
            time_low_reg      <= time_low_next;
            time_high_reg     <= time_high_next;
            compare_value_reg <= compare_value_next;
            compare_hit_reg   <= compare_hit_next;
            beat_interval_reg <= beat_interval_next;
            last_tap_time_reg <= last_tap_time_next;
            tap_count_reg     <= tap_count_next;
            tapping_on_reg    <= tapping_on_next;
            beat_phase_reg    <= beat_phase_next;
            led_pending_reg   <= led_pending_next;
            led_shown_reg     <= led_shown_next;
            phase_shown_reg   <= phase_shown_next;
            prev_buttons_reg  <= prev_buttons_next;
            presses_reg       <= presses_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    a_count_needs_tapping: assert property (@(posedge aclk) disable iff (!aresetn)
        !tapping_on_reg |-> (tap_count_reg == '0))
        else $error("tap count nonzero while tapping is off");

    a_divider_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == ST_DIVIDE))
        else $error("divider result outside the divide step");

    a_divider_idle_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_status.busy)
        else $error("divider busy while idle");

endmodule

### hw/rtl/tt_beat_divider.sv
// Iterative restoring divider: one quotient bit per cycle.
module tt_beat_divider #(
    parameter int DIVIDEND_W = tt_beat_pkg::TT_DIVIDEND_W,
    parameter int DIVISOR_W  = tt_beat_pkg::TT_COUNT_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [DIVIDEND_W-1:0]      dividend,
    input  logic [DIVISOR_W-1:0]       divisor,
    output logic [DIVIDEND_W-1:0]      quotient,
    output tt_beat_pkg::tt_div_status_t status
);
    import tt_beat_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    assign trial = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quot_next = dividend;
            div_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Subtract when the trial remainder covers the divisor.
            if (trial >= {1'b0, div_reg}) begin
                rem_next  = diff[DIVISOR_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[DIVISOR_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### verif/tap_tempo_beat_generator_core_test.sv
// Self-checking testbench for tap_tempo_beat_generator_core: directed and random stream traffic.
module tap_tempo_beat_generator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tt_beat_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_CAP   = 30;

    typedef struct packed {
        logic tap_button;
        logic start_button;
        logic frame_strobe;
        logic timer_tick;
    } beat_in_t;

    typedef struct packed {
        logic       tapping;
        logic [3:0] led;
        logic [3:0] phase;
    } beat_out_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [TT_S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [TT_M_DATA_W-1:0]   m_axis_tdata;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [TT_CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [TT_CFG_DATA_W-1:0] cfg_wdata     = '0;

    tap_tempo_beat_generator_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Predictor state and register mirror
    logic [15:0]              min_ticks;
    logic [3:0]               tap_gap_max;
    logic [3:0]               idle_gap_max;
    logic [15:0]              elapsed_lo;
    logic [7:0]               elapsed_hi;
    logic [15:0]              match_at;
    logic                     match_flag;
    logic [15:0]              beat_len;
    logic [23:0]              tap_stamp;
    logic [7:0]               tap_tally;
    logic                     tap_live;
    logic [TT_PHASE_BITS-1:0] beat_pos;
    logic [3:0]               led_next;
    logic [3:0]               led_now;
    logic [3:0]               pos_now;
    logic [1:0]               btn_last;
    logic [1:0]               btn_edges;

    beat_in_t  beat_stim_q[$];
    beat_out_t beat_expect_q[$];

    logic full_rate = 1'b0;
    int   items_sent, results_seen, mismatches, taps_taken, tap_stops;
    int   send_gap, send_calm, sink_gap, sink_calm, sink_hold, idle_cycles;

    function automatic logic [15:0] sixteenth();
        logic [16:0] sum;
        sum = {1'b0, beat_len} + 17'd8;
        return 16'(sum >> 4);
    endfunction

    function automatic beat_out_t advance_beat(beat_in_t t);
        logic [1:0]               edges;
        logic [23:0]              now;
        logic [23:0]              since;
        logic [TT_PHASE_BITS-1:0] old_pos;
        int unsigned              mean;
        logic                     quit_tap;
        beat_out_t                r;
        if (t.timer_tick) begin
            elapsed_lo = elapsed_lo + 16'd1;
            if (elapsed_lo == 16'd0)
                elapsed_hi = elapsed_hi + 8'd1;
            if (elapsed_lo == match_at)
                match_flag = 1'b1;
        end
        if (t.frame_strobe) begin
            led_now   = led_next;
            led_next  = '0;
            pos_now   = 4'(beat_pos);
            btn_edges = btn_edges | ({t.tap_button, t.start_button} & ~btn_last);
            btn_last  = {t.tap_button, t.start_button};
        end
        edges     = btn_edges;
        btn_edges = '0;
        now       = {elapsed_hi, elapsed_lo};

        if (edges[0]) begin
            elapsed_lo = '0;
            elapsed_hi = '0;
            now        = '0;
            match_at   = sixteenth();
            match_flag = 1'b0;
            tap_live   = 1'b1;
            led_next   = 4'hF;
            beat_pos   = '0;
            tap_stamp  = '0;
            tap_tally  = '0;
        end else if (tap_live && edges[1] && now > 24'(min_ticks)) begin
            if (tap_tally != 8'hFF)
                tap_tally = tap_tally + 8'd1;
            tap_stamp = now;
            mean = (32'(now) + 32'(tap_tally >> 1)) / 32'(tap_tally);
            if (mean > 32'hFFFF)
                mean = 32'hFFFF;
            if (mean > 32'(min_ticks))
                beat_len = mean[15:0];
            match_at = tap_stamp[15:0] + sixteenth();
            taps_taken++;
        end

        if (match_flag) begin
            old_pos    = beat_pos;
            match_at   = match_at + sixteenth();
            match_flag = 1'b0;
            beat_pos   = beat_pos + 1'b1;
            led_next   = 4'(old_pos & ~beat_pos);
            if (tap_live && now != 0 && beat_len > min_ticks) begin
                since = now - tap_stamp;
                quit_tap = (tap_tally != 0 && 32'(since) > 32'(tap_gap_max) * 32'(beat_len))
                           || 32'(since) > 32'(idle_gap_max) * 32'(beat_len);
                if (quit_tap) begin
                    tap_live  = 1'b0;
                    tap_tally = '0;
                    tap_stamp = '0;
                    tap_stops++;
                end
            end
        end

        r.phase   = pos_now;
        r.led     = led_now;
        r.tapping = tap_live;
        return r;
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm = $urandom_range(20, 60);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
    endtask

    // Driver: present queued items, predict on every accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                beat_expect_q.push_back(advance_beat(beat_in_t'(s_axis_tdata[3:0])));
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (beat_stim_q.size() > 0) begin
                    s_axis_tdata  <= TT_S_DATA_W'(beat_stim_q.pop_front());
                    s_axis_tvalid <= 1'b1;
                    send_gap = full_rate ? 0 : pick_gap(send_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        beat_out_t got;
        beat_out_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
            sink_hold = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = beat_out_t'(m_axis_tdata[8:0]);
                results_seen++;
                if (beat_expect_q.size() == 0) begin
                    flag_mismatch("result with nothing pending", m_axis_tdata, '0);
                end else begin
                    want = beat_expect_q.pop_front();
                    if (got.phase !== want.phase)
                        flag_mismatch("phase_out", 16'(got.phase), 16'(want.phase));
                    if (got.led !== want.led)
                        flag_mismatch("led_out", 16'(got.led), 16'(want.led));
                    if (got.tapping !== want.tapping)
                        flag_mismatch("tapping_flag", 16'(got.tapping), 16'(want.tapping));
                end
                // hold off long now and then so the block backs up its input
                if (!full_rate && results_seen % 150 == 75)
                    sink_hold = $urandom_range(200, 400);
                else
                    sink_gap = full_rate ? 0 : pick_gap(sink_calm);
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("** tap_tempo_beat_generator_core: FAILED **");
                $finish;
            end
        end
    end

    task automatic queue_item(input bit tick, input bit strobe, input bit start, input bit tap);
        beat_in_t t;
        t.timer_tick   = tick;
        t.frame_strobe = strobe;
        t.start_button = start;
        t.tap_button   = tap;
        beat_stim_q.push_back(t);
    endtask

    task automatic wait_drained();
        do
            @(posedge aclk);
        while (beat_stim_q.size() != 0 || s_axis_tvalid || beat_expect_q.size() != 0);
    endtask

    task automatic write_reg(input logic [TT_CFG_ADDR_W-1:0] idx,
                             input logic [TT_CFG_DATA_W-1:0] val);
        cfg_addr  <= idx;
        cfg_wdata <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            CFG_MIN_INTERVAL:  min_ticks   = val;
            CFG_TAP_GAP_LIMIT: tap_gap_max = val[3:0];
            default:           idle_gap_max = val[3:0];
        endcase
    endtask

    task automatic program_regs(input logic [15:0] min_v, input logic [3:0] tap_v,
                                input logic [3:0] idle_v);
        write_reg(CFG_MIN_INTERVAL, min_v);
        write_reg(CFG_TAP_GAP_LIMIT, 16'(tap_v));
        write_reg(CFG_IDLE_GAP_LIMIT, 16'(idle_v));
        cfg_valid <= 1'b0;
    endtask

    // release both buttons, press start, release again
    task automatic press_start();
        queue_item(0, 1, 0, 0);
        queue_item(0, 1, 1, 0);
        queue_item(1, 1, 0, 0);
    endtask

    // Taps at a rough cadence during the first two thirds, then let the beat run out
    task automatic tap_session(input int count, input int period);
        int until_tap;
        int hold;
        bit tap_lvl;
        press_start();
        until_tap = period;
        hold = 0;
        tap_lvl = 0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                if (hold > 0)
                    hold--;
                else
                    tap_lvl = 0;
                if (i < count * 2 / 3) begin
                    if (until_tap == 0) begin
                        tap_lvl = 1;
                        hold = $urandom_range(1, 3);
                        until_tap = period + $urandom_range(0, period / 4) - period / 8;
                    end else begin
                        until_tap--;
                    end
                end
                queue_item($urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)),
                           $urandom_range(0, 149) == 0, tap_lvl);
            end
        end
    endtask

    initial begin
        min_ticks = MIN_INTERVAL_RST;
        tap_gap_max = TAP_GAP_LIMIT_RST;
        idle_gap_max = IDLE_GAP_LIMIT_RST;
        {elapsed_lo, elapsed_hi, match_at, match_flag, beat_len, tap_stamp, tap_tally} = '0;
        {tap_live, beat_pos, led_next, led_now, pos_now, btn_last, btn_edges} = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, default registers: tap while off, start, tap too early
        queue_item(0, 0, 0, 0);
        queue_item(1, 0, 0, 0);
        queue_item(0, 1, 0, 1);
        queue_item(0, 1, 0, 0);
        queue_item(0, 1, 1, 0);
        queue_item(1, 1, 1, 1);
        queue_item(0, 1, 0, 0);
        wait_drained();

        // Zero limits: the first match after a valid tap stops tapping
        program_regs(16'd0, 4'd0, 4'd0);
        queue_item(0, 1, 1, 0);
        queue_item(0, 1, 0, 0);
        repeat (8) queue_item(1, 0, 0, 0);
        queue_item(0, 1, 0, 1);
        queue_item(1, 0, 0, 0);
        queue_item(0, 1, 0, 0);
        queue_item(1, 1, 0, 1);
        wait_drained();

        program_regs(16'd20, 4'd1, 4'd1);
        tap_session(90, 40);
        wait_drained();
        program_regs(16'd10, 4'd15, 4'd15);
        tap_session(90, 25);
        wait_drained();
        program_regs(16'd30, 4'd2, 4'd7);
        tap_session(90, 70);
        wait_drained();

        // Back to back at full rate with dense taps and short limits
        program_regs(16'd0, 4'd1, 4'd2);
        full_rate <= 1'b1;
        press_start();
        repeat (15) begin
            queue_item(1, 1, 0, 0);
            queue_item(1, 1, 0, 1);
        end
        wait_drained();
        full_rate <= 1'b0;

        program_regs(16'd40, 4'd3, 4'd5);
        tap_session(60, 50);

        wait_drained();
        repeat (40) @(posedge aclk);
        $display("Run: %0d input transactions, %0d results checked, %0d taps accepted,",
                 items_sent, results_seen, taps_taken);
        $display("     %0d tapping stops over several tempos and register settings", tap_stops);
        if (mismatches == 0)
            $display("** tap_tempo_beat_generator_core: PASSED **");
        else
            $display("** tap_tempo_beat_generator_core: FAILED **");
        $finish;
    end

endmodule

### tap_tempo_beat_generator_core.f
hw/rtl/tt_beat_pkg.sv
hw/rtl/tt_beat_divider.sv
hw/rtl/tap_tempo_beat_generator_core.sv
verif/tap_tempo_beat_generator_core_test.sv
